// ===== hdl/rcr_pkg.sv =====
// ----------------------------------------------------------------------------
// rcr_pkg : shared types and constants of the RGB 3x3 convolution unit
// Pixel and tap-grid types, geometry limits, register indexes and the
// built-in kernel coefficient table (8 fraction bits).
// ----------------------------------------------------------------------------
`default_nettype none

package rcr_pkg;

   // geometry
   localparam int MAX_WIDTH    = 2048;
   localparam int MAX_HEIGHT   = 4096;
   localparam int ADDR_W       = $clog2(MAX_WIDTH);
   localparam int WIDTH_W      = ADDR_W + 1;
   localparam int ROW_W        = $clog2(MAX_HEIGHT);
   localparam int HEIGHT_W     = ROW_W + 1;
   localparam int WIDTH_RESET  = 640;
   localparam int HEIGHT_RESET = 480;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = HEIGHT_W;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_KERNEL = 2'd2
   } csr_idx_type;

   // pixel format
   localparam int CH_W  = 8;
   localparam int PIX_W = 3 * CH_W;
   localparam int TAPS  = 9;

   typedef struct packed {
      logic [CH_W-1:0] blue;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] red;
   } pix_type;

   typedef pix_type [TAPS-1:0] grid_type;

   typedef struct packed {
      logic valid;
      logic last;
   } tag_type;

   // arithmetic widths
   localparam int FRAC_BITS = 8;
   localparam int COEF_W    = 13;
   localparam int PROD_W    = COEF_W + CH_W + 1;
   localparam int PART_W    = PROD_W + 2;
   localparam int SUM_W     = PART_W + 2;

   // kernel numbers
   localparam int KSEL_W = 4;
   localparam logic [KSEL_W-1:0] K_BLUR    = 4'd1;
   localparam logic [KSEL_W-1:0] K_EMBOSS  = 4'd2;
   localparam logic [KSEL_W-1:0] K_SHARPEN = 4'd3;
   localparam logic [KSEL_W-1:0] K_OUTLINE = 4'd4;
   localparam logic [KSEL_W-1:0] K_SOBEL   = 4'd5;
   localparam logic [KSEL_W-1:0] K_RIDGE   = 4'd6;
   localparam logic [KSEL_W-1:0] K_EDGE    = 4'd7;
   localparam logic [KSEL_W-1:0] K_BOX     = 4'd8;

   typedef logic signed [COEF_W-1:0] coef_row_type [0:TAPS-1];

   // coefficients in raster tap order, scaled by 2^FRAC_BITS
   function automatic coef_row_type kernel_row(input logic [KSEL_W-1:0] k);
      coef_row_type row;
      unique case (k)
         K_BLUR:    row = '{16, 32, 16, 32, 64, 32, 16, 32, 16};
         K_EMBOSS:  row = '{512, -256, 0, -256, 256, 256, 0, 256, 512};
         K_SHARPEN: row = '{0, -256, 0, -256, 1280, -256, 0, -256, 0};
         K_OUTLINE,
         K_EDGE:    row = '{-256, -256, -256, -256, 2048, -256, -256, -256, -256};
         K_SOBEL:   row = '{-256, -512, -256, 0, 0, 0, 256, 512, 256};
         K_RIDGE:   row = '{0, -256, 0, -256, 1024, -256, 0, -256, 0};
         K_BOX:     row = '{28, 28, 28, 28, 28, 28, 28, 28, 28};
         default:   row = '{0, 0, 0, 0, 256, 0, 0, 0, 0};
      endcase
      return row;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/rgb_conv3x3_reflect_unit.sv =====
// ----------------------------------------------------------------------------
// rgb_conv3x3_reflect_unit : streaming 3x3 RGB convolution, reflected border
// Line stores in two dual-read memories, a 3x3 window in registers and a
// multiply-accumulate pipeline with an output register and skid stage.
// ----------------------------------------------------------------------------
// Usage:
//  req_* takes pixels in raster order (tuser = flush). A pixel accepted in
//  frame input gives at most one result (the pixel one row and one column
//  back). Once the last pixel of a frame is in, every transaction on req_*
//  (flush or pixel, its data dropped) releases one pending result, the
//  last of the frame carrying rsp_tlast. Flush items during frame input
//  are discarded.
//  Throughput: one transaction per clock while the skid stage is not
//  full, set by the single read-modify-write of each line store per
//  pixel; back-to-back accesses to the same column are forwarded.
//  Registers on the path: stage 1, tap grid, products, partial sums, output.
//  Stall: rsp_tready low fills the output register, then the skid stage;
//  req_tready drops while the skid stage is full, and the pipeline freezes.
//  Reset: geometry 640x480, identity kernel, frame restarted. Line stores
//  have no clearing pass. Writing width or height restarts the frame;
//  the user makes csr_* writes only while the unit is idle (not enforced).
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_conv3x3_reflect_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [rcr_pkg::PIX_W-1:0]        req_tdata,   // red, green, blue
   input  logic                             req_tuser,   // flush
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [rcr_pkg::PIX_W-1:0]        rsp_tdata,   // red, green, blue
   output logic                             rsp_tlast,   // frame_end
   input  logic                             csr_we,
   input  logic [rcr_pkg::CSR_IDX_W-1:0]    csr_addr,
   input  logic [rcr_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import rcr_pkg::*;

   typedef enum logic {SRC_WINDOW, SRC_LINES} src_type;

   typedef struct packed {
      logic              wr;         // pixel into line stores and window
      logic              res;        // produces a result
      logic              last;
      src_type           src;
      logic              top_lower;  // top row reflected onto the middle row
      logic              left_mid;   // left column reflected onto the centre
      logic              right_new;  // right column is the incoming column
      logic [ADDR_W-1:0] addr;
   } s1_ctrl_type;

   // configuration
   logic [WIDTH_W-1:0]  width_ff;
   logic [HEIGHT_W-1:0] height_ff;
   logic [KSEL_W-1:0]   ksel_ff;
   logic [WIDTH_W-1:0]  width_wr;
   logic [HEIGHT_W-1:0] height_wr;
   logic                geom_wr;

   // frame position
   logic [ADDR_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic                done_ff, done_in;
   logic                drain_win_ff, drain_win_in;
   logic [ADDR_W-1:0]   dx_ff, dx_in;
   logic                col_last, row_last, dx_last;

   // handshake
   logic                en;
   logic                accept;

   // stage 1
   s1_ctrl_type         s1_in, s1_ff;
   pix_type             s1_pix_ff;
   logic [ADDR_W-1:0]   addr_b;

   // line stores
   pix_type             upper_mem [0:MAX_WIDTH-1];
   pix_type             lower_mem [0:MAX_WIDTH-1];
   pix_type             up_a_ff, lo_a_ff, up_b_ff, lo_b_ff;
   pix_type             fwd_up_ff, fwd_lo_ff;
   logic                fwd_a_ff, fwd_b_ff;
   logic                wr_now;
   pix_type             up_a, lo_a, up_b, lo_b;

   // window and drain history
   pix_type             win_ff [0:2][0:2];
   pix_type             newcol [0:2];
   pix_type             prev_up_ff, prev_lo_ff;
   grid_type            grid;
   grid_type            tap_ff;
   tag_type             tag1_ff;

   // datapath output and output buffering
   tag_type             mac_tag;
   pix_type             mac_pix;
   logic                inc_v;
   pix_type             out_ff, skid_ff;
   logic                out_last_ff, skid_last_ff;
   logic                out_v_ff, skid_v_ff;

   // register write values, clamped into range
   always_comb begin
      width_wr  = csr_wdata[WIDTH_W-1:0];
      height_wr = csr_wdata[HEIGHT_W-1:0];
      if (width_wr == '0) begin
         width_wr = WIDTH_W'(1);
      end else if (width_wr > WIDTH_W'(MAX_WIDTH)) begin
         width_wr = WIDTH_W'(MAX_WIDTH);
      end
      if (height_wr == '0) begin
         height_wr = HEIGHT_W'(1);
      end else if (height_wr > HEIGHT_W'(MAX_HEIGHT)) begin
         height_wr = HEIGHT_W'(MAX_HEIGHT);
      end
      geom_wr = csr_we && (csr_addr == CSR_WIDTH || csr_addr == CSR_HEIGHT);
   end

   assign en         = !skid_v_ff;
   assign req_tready = en;
   assign accept     = req_tvalid && en;

   assign col_last = ({1'b0, col_ff} == width_ff - WIDTH_W'(1));
   assign row_last = ({1'b0, row_ff} == height_ff - HEIGHT_W'(1));
   assign dx_last  = ({1'b0, dx_ff} == width_ff - WIDTH_W'(1));
   assign addr_b   = dx_last ? dx_ff : dx_ff + ADDR_W'(1);

   // stage 0: classify the transaction, step the frame position
   always_comb begin
      s1_in        = '0;
      col_in       = col_ff;
      row_in       = row_ff;
      done_in      = done_ff;
      drain_win_in = drain_win_ff;
      dx_in        = dx_ff;
      if (accept) begin
         if (done_ff) begin
            s1_in.res = 1'b1;
            if (drain_win_ff) begin
               // last pixel of the next-to-last row, from the window
               s1_in.src       = SRC_WINDOW;
               s1_in.top_lower = (height_ff == HEIGHT_W'(2));
               s1_in.left_mid  = (width_ff == WIDTH_W'(1));
               drain_win_in    = 1'b0;
            end else begin
               // last row, from the line stores
               s1_in.src       = SRC_LINES;
               s1_in.top_lower = (height_ff == HEIGHT_W'(1));
               s1_in.left_mid  = (dx_ff == '0);
               s1_in.last      = dx_last;
               s1_in.addr      = dx_ff;
               if (dx_last) begin
                  done_in = 1'b0;
                  dx_in   = '0;
               end else begin
                  dx_in = dx_ff + ADDR_W'(1);
               end
            end
         end else if (!req_tuser) begin
            s1_in.wr   = 1'b1;
            s1_in.addr = col_ff;
            s1_in.src  = SRC_WINDOW;
            if (col_ff == '0 && row_ff >= ROW_W'(2)) begin
               // end of the row two back
               s1_in.res       = 1'b1;
               s1_in.top_lower = (row_ff == ROW_W'(2));
               s1_in.left_mid  = (width_ff == WIDTH_W'(1));
            end else if (col_ff != '0 && row_ff != '0) begin
               s1_in.res       = 1'b1;
               s1_in.top_lower = (row_ff == ROW_W'(1));
               s1_in.left_mid  = (col_ff == ADDR_W'(1));
               s1_in.right_new = 1'b1;
            end
            if (col_last) begin
               col_in = '0;
               if (row_last) begin
                  row_in       = '0;
                  done_in      = 1'b1;
                  drain_win_in = (height_ff >= HEIGHT_W'(2));
                  dx_in        = '0;
               end else begin
                  row_in = row_ff + ROW_W'(1);
               end
            end else begin
               col_in = col_ff + ADDR_W'(1);
            end
         end
      end
   end

   // configuration and frame position
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WIDTH_W'(WIDTH_RESET);
         height_ff    <= HEIGHT_W'(HEIGHT_RESET);
         ksel_ff      <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         done_ff      <= 1'b0;
         drain_win_ff <= 1'b0;
         dx_ff        <= '0;
      end else begin
         if (geom_wr) begin
            col_ff       <= '0;
            row_ff       <= '0;
            done_ff      <= 1'b0;
            drain_win_ff <= 1'b0;
            dx_ff        <= '0;
         end else begin
            col_ff       <= col_in;
            row_ff       <= row_in;
            done_ff      <= done_in;
            drain_win_ff <= drain_win_in;
            dx_ff        <= dx_in;
         end
         if (csr_we) begin
            unique case (csr_addr)
               CSR_WIDTH:  width_ff  <= width_wr;
               CSR_HEIGHT: height_ff <= height_wr;
               CSR_KERNEL: ksel_ff   <= csr_wdata[KSEL_W-1:0];
               default:    ;
            endcase
         end
      end
   end

   // stage 1 control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
      end else if (en) begin
         s1_ff <= s1_in;
      end
   end

   // line store reads, with forwarding of the write in flight
   assign wr_now = en && s1_ff.wr;

   always_ff @(posedge clock) begin
      if (en) begin
         s1_pix_ff <= pix_type'(req_tdata);
         up_a_ff   <= upper_mem[s1_in.addr];
         lo_a_ff   <= lower_mem[s1_in.addr];
         up_b_ff   <= upper_mem[addr_b];
         lo_b_ff   <= lower_mem[addr_b];
         fwd_a_ff  <= wr_now && (s1_ff.addr == s1_in.addr);
         fwd_b_ff  <= wr_now && (s1_ff.addr == addr_b);
         fwd_up_ff <= lo_a;
         fwd_lo_ff <= s1_pix_ff;
      end
   end

   assign up_a = fwd_a_ff ? fwd_up_ff : up_a_ff;
   assign lo_a = fwd_a_ff ? fwd_lo_ff : lo_a_ff;
   assign up_b = fwd_b_ff ? fwd_up_ff : up_b_ff;
   assign lo_b = fwd_b_ff ? fwd_lo_ff : lo_b_ff;

   // line store write back: rows shift down one
   always_ff @(posedge clock) begin
      if (wr_now) begin
         upper_mem[s1_ff.addr] <= lo_a;
         lower_mem[s1_ff.addr] <= s1_pix_ff;
      end
   end

   assign newcol[0] = up_a;
   assign newcol[1] = lo_a;
   assign newcol[2] = s1_pix_ff;

   // window shift and drain history
   always_ff @(posedge clock) begin
      if (wr_now) begin
         for (int i = 0; i < 3; i++) begin
            win_ff[i][0] <= win_ff[i][1];
            win_ff[i][1] <= win_ff[i][2];
            win_ff[i][2] <= newcol[i];
         end
      end
      if (en && s1_ff.res && s1_ff.src == SRC_LINES) begin
         prev_up_ff <= up_a;
         prev_lo_ff <= lo_a;
      end
   end

   // tap grid with border reflection
   always_comb begin
      logic [1:0] ri;
      pix_type    t_prev, t_mid, t_next;
      for (int i = 0; i < 3; i++) begin
         ri     = (i == 0 && s1_ff.top_lower) ? 2'd1 : 2'(i);
         t_prev = prev_lo_ff;
         t_mid  = lo_a;
         t_next = lo_b;
         unique case (s1_ff.src)
            SRC_WINDOW: begin
               grid[3*i]   = s1_ff.left_mid ? win_ff[ri][2] : win_ff[ri][1];
               grid[3*i+1] = win_ff[ri][2];
               grid[3*i+2] = s1_ff.right_new ? newcol[ri] : win_ff[ri][2];
            end
            SRC_LINES: begin
               if (i == 0 && !s1_ff.top_lower) begin
                  t_prev = prev_up_ff;
                  t_mid  = up_a;
                  t_next = up_b;
               end else begin
                  t_prev = prev_lo_ff;
                  t_mid  = lo_a;
                  t_next = lo_b;
               end
               grid[3*i]   = s1_ff.left_mid ? t_mid : t_prev;
               grid[3*i+1] = t_mid;
               grid[3*i+2] = t_next;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff <= grid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
      end else if (en) begin
         tag1_ff.valid <= s1_ff.res;
         tag1_ff.last  <= s1_ff.last;
      end
   end

   rcr_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .tag_in     (tag1_ff),
      .taps_in    (tap_ff),
      .kernel_sel (ksel_ff),
      .tag_out    (mac_tag),
      .pix_out    (mac_pix)
   );

   // output register and skid stage
   assign inc_v = en && mac_tag.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (rsp_tready) begin
            out_ff      <= skid_ff;
            out_last_ff <= skid_last_ff;
            skid_v_ff   <= 1'b0;
         end
      end else if (!out_v_ff || rsp_tready) begin
         out_v_ff    <= inc_v;
         out_ff      <= mac_pix;
         out_last_ff <= mac_tag.last;
      end else if (inc_v) begin
         skid_v_ff    <= 1'b1;
         skid_ff      <= mac_pix;
         skid_last_ff <= mac_tag.last;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_ff;
   assign rsp_tlast  = out_last_ff;

   // checks
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid stage full while output register empty");

   a_drain_pos: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (col_ff == '0 && row_ff == '0))
      else $error("input position moved after frame input ended");

   a_drain_win: assert property (@(posedge clock) disable iff (reset)
      drain_win_ff |-> done_ff)
      else $error("window drain pending outside drain phase");

   a_dx_idle: assert property (@(posedge clock) disable iff (reset)
      !done_ff |-> dx_ff == '0)
      else $error("drain column not cleared");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, col_ff} < width_ff && {1'b0, dx_ff} < width_ff)
      else $error("column beyond image width");

endmodule

`default_nettype wire

// ===== hdl/rcr_mac.sv =====
// ----------------------------------------------------------------------------
// rcr_mac : multiply-accumulate pipeline of the 3x3 convolution
// Steps: 27 coefficient products, partial sums of three, then the
// final sum (combinational) and clamp to 0..255. All registers advance on en.
// ----------------------------------------------------------------------------
`default_nettype none

module rcr_mac (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  rcr_pkg::tag_type              tag_in,
   input  rcr_pkg::grid_type             taps_in,
   input  logic [rcr_pkg::KSEL_W-1:0]    kernel_sel,
   output rcr_pkg::tag_type              tag_out,
   output rcr_pkg::pix_type              pix_out
);
   import rcr_pkg::*;

   coef_row_type              coef;
   logic [CH_W-1:0]           px       [0:2][0:TAPS-1];
   logic signed [PROD_W-1:0]  prod_in  [0:2][0:TAPS-1];
   logic signed [PROD_W-1:0]  prod_ff  [0:2][0:TAPS-1];
   logic signed [PART_W-1:0]  part_in  [0:2][0:2];
   logic signed [PART_W-1:0]  part_ff  [0:2][0:2];
   logic signed [SUM_W-1:0]   total    [0:2];
   logic [CH_W-1:0]           chan_out [0:2];
   tag_type                   tag2_ff;
   tag_type                   tag3_ff;

   // negative gives 0, otherwise drop fraction and saturate
   function automatic logic [CH_W-1:0] clamp(input logic signed [SUM_W-1:0] v);
      logic [CH_W-1:0] r;
      if (v[SUM_W-1]) begin
         r = '0;
      end else if (|v[SUM_W-2:FRAC_BITS+CH_W]) begin
         r = '1;
      end else begin
         r = v[FRAC_BITS+CH_W-1:FRAC_BITS];
      end
      return r;
   endfunction

   assign coef = kernel_row(kernel_sel);

   // split taps into channels
   always_comb begin
      for (int t = 0; t < TAPS; t++) begin
         px[0][t] = taps_in[t].red;
         px[1][t] = taps_in[t].green;
         px[2][t] = taps_in[t].blue;
      end
   end

   // products
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         for (int t = 0; t < TAPS; t++) begin
            prod_in[c][t] = coef[t] * $signed({1'b0, px[c][t]});
         end
      end
   end

   // partial sums, one per kernel row
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         for (int g = 0; g < 3; g++) begin
            part_in[c][g] = PART_W'(prod_ff[c][3*g]) + PART_W'(prod_ff[c][3*g+1])
                          + PART_W'(prod_ff[c][3*g+2]);
         end
      end
   end

   // final sum and clamp
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         total[c]    = SUM_W'(part_ff[c][0]) + SUM_W'(part_ff[c][1])
                     + SUM_W'(part_ff[c][2]);
         chan_out[c] = clamp(total[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         part_ff <= part_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag2_ff <= '0;
         tag3_ff <= '0;
      end else if (en) begin
         tag2_ff <= tag_in;
         tag3_ff <= tag2_ff;
      end
   end

   assign tag_out       = tag3_ff;
   assign pix_out.red   = chan_out[0];
   assign pix_out.green = chan_out[1];
   assign pix_out.blue  = chan_out[2];

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb : self-checking bench for rgb_conv3x3_reflect_unit
// Drives raster-order pixel frames with flush transactions through req_*,
// predicts every filtered pixel with a behavioural model of the reflected
// 3x3 convolution, and compares it with each rsp_* transaction in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb;
   import rcr_pkg::*;

   localparam int WATCHDOG = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [PIX_W-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [PIX_W-1:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_addr = CSR_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   typedef struct packed {
      logic       last;
      logic [7:0] b;
      logic [7:0] g;
      logic [7:0] r;
   } px_out_type;

   // convolution model state
   logic [23:0] upper_line [MAX_WIDTH];
   logic [23:0] lower_line [MAX_WIDTH];
   logic [23:0] win [9];
   int unsigned col, row, out_cnt, img_w, img_h, ksel;
   bit frame_in_done;

   px_out_type pending_px [$];
   int errors = 0;
   int n_rsp = 0;
   int n_frames = 0;
   int n_sent = 0;
   int idle_cycles = 0;

   always #5 clock = ~clock;

   rgb_conv3x3_reflect_unit u_top (.*);

   // fixed-point weight of one tap (8 fraction bits)
   function automatic int weight(int unsigned tap);
      int unsigned k;
      int t16 [8][9];
      t16 = '{'{0, 0, 0, 0, 16, 0, 0, 0, 0}, '{1, 2, 1, 2, 4, 2, 1, 2, 1},
              '{32, -16, 0, -16, 16, 16, 0, 16, 32},
              '{0, -16, 0, -16, 80, -16, 0, -16, 0},
              '{-16, -16, -16, -16, 128, -16, -16, -16, -16},
              '{-16, -32, -16, 0, 0, 0, 16, 32, 16},
              '{0, -16, 0, -16, 64, -16, 0, -16, 0},
              '{-16, -16, -16, -16, 128, -16, -16, -16, -16}};
      k = ksel;
      if (k == 8) return 28;
      if (k > 8) k = 0;
      return t16[k][tap] * 16;
   endfunction

   function automatic px_out_type filter(logic [23:0] grid [9], bit last);
      px_out_type o;
      int acc;
      logic [7:0] ch [3];
      for (int s = 0; s < 3; s++) begin
         acc = 0;
         for (int t = 0; t < 9; t++)
            acc += weight(t) * int'(grid[t][16-8*s +: 8]);
         if (acc < 0) ch[s] = 8'd0;
         else if ((acc >>> 8) > 255) ch[s] = 8'd255;
         else ch[s] = acc[15:8];
      end
      o.r = ch[0]; o.g = ch[1]; o.b = ch[2]; o.last = last;
      return o;
   endfunction

   function automatic void pick(output logic [23:0] grid [9], input int unsigned top,
                                input int unsigned l, m, r);
      int unsigned rs [3];
      rs = '{top, 1, 2};
      for (int i = 0; i < 3; i++) begin
         grid[i*3]   = win[rs[i]*3 + l];
         grid[i*3+1] = win[rs[i]*3 + m];
         grid[i*3+2] = win[rs[i]*3 + r];
      end
   endfunction

   function automatic void restart();
      col = 0; row = 0; out_cnt = 0; frame_in_done = 0;
   endfunction

   function automatic void set_reg(csr_idx_type idx, int unsigned v);
      case (idx)
         CSR_WIDTH: begin
            v &= 'hFFF; img_w = (v == 0) ? 1 : (v > MAX_WIDTH ? MAX_WIDTH : v); restart();
         end
         CSR_HEIGHT: begin
            v &= 'h1FFF; img_h = (v == 0) ? 1 : (v > MAX_HEIGHT ? MAX_HEIGHT : v); restart();
         end
         CSR_KERNEL: ksel = v & 'hF;
         default: ;
      endcase
   endfunction

   // advance the model by one accepted transaction
   function automatic void predict_filtered(bit fl, logic [23:0] pix);
      logic [23:0] grid [9];
      int unsigned n, oy, ox, o;
      int unsigned xs [3];
      bit got, last;
      logic [23:0] u, l;
      got = 0;
      if (frame_in_done) begin
         o = out_cnt; oy = o / img_w; ox = o % img_w;
         last = (o + 1 == img_w * img_h);
         if (oy + 1 < img_h)
            pick(grid, oy == 0 ? 1 : 0, img_w == 1 ? 2 : 1, 2, 2);
         else begin
            xs[0] = ox == 0 ? 0 : ox - 1;
            xs[1] = ox;
            xs[2] = (ox + 1 < img_w) ? ox + 1 : ox;
            for (int i = 0; i < 3; i++) begin
               grid[i]   = (img_h >= 2) ? upper_line[xs[i]] : lower_line[xs[i]];
               grid[3+i] = lower_line[xs[i]];
               grid[6+i] = lower_line[xs[i]];
            end
         end
         pending_px.push_back(filter(grid, last));
         out_cnt++;
         if (last) begin
            restart();
            n_frames++;
         end
         return;
      end
      if (fl) return;
      n = row * img_w + col;
      if (col == 0 && n >= img_w + 1) begin
         pick(grid, row - 2 == 0 ? 1 : 0, img_w == 1 ? 2 : 1, 2, 2);
         pending_px.push_back(filter(grid, 0));
         got = 1;
      end
      u = upper_line[col]; l = lower_line[col];
      upper_line[col] = l;
      lower_line[col] = pix;
      for (int i = 0; i < 3; i++) begin
         win[i*3] = win[i*3+1];
         win[i*3+1] = win[i*3+2];
      end
      win[2] = u; win[5] = l; win[8] = pix;
      if (col >= 1 && n >= img_w + 1) begin
         pick(grid, row - 1 == 0 ? 1 : 0, col - 1 == 0 ? 1 : 0, 1, 2);
         pending_px.push_back(filter(grid, 0));
         got = 1;
      end
      if (got) out_cnt++;
      if (col + 1 >= img_w) begin
         col = 0;
         if (row + 1 >= img_h) begin
            row = 0; frame_in_done = 1;
         end else row++;
      end else col++;
   endfunction

   // result checker and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > WATCHDOG) begin
            $display("Some tests failed");
            $finish;
         end
         if (rsp_tvalid && rsp_tready) begin
            n_rsp++;
            if (pending_px.size() == 0) begin
               $display("%0t: unexpected result %h last %b", $time, rsp_tdata, rsp_tlast);
               errors++;
            end else begin
               px_out_type e;
               e = pending_px.pop_front();
               if (rsp_tdata[7:0] !== e.r) begin
                  $display("%0t: red exp %h got %h", $time, e.r, rsp_tdata[7:0]); errors++;
               end
               if (rsp_tdata[15:8] !== e.g) begin
                  $display("%0t: green exp %h got %h", $time, e.g, rsp_tdata[15:8]); errors++;
               end
               if (rsp_tdata[23:16] !== e.b) begin
                  $display("%0t: blue exp %h got %h", $time, e.b, rsp_tdata[23:16]); errors++;
               end
               if (rsp_tlast !== e.last) begin
                  $display("%0t: frame_end exp %b got %b", $time, e.last, rsp_tlast);
                  errors++;
               end
            end
         end
      end
   end

   // receiver stall pattern: phases of free flow and random back-pressure
   int unsigned stall_phase = 0;
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      if (stall_phase[8]) rsp_tready <= 1'b1;
      else if (stall_phase[6]) rsp_tready <= ($urandom_range(0, 3) != 0);
      else rsp_tready <= ($urandom_range(0, 1) != 0);
   end

   int burst_left = 0;

   // one transaction, with random gaps between bursts; valid stays up in a burst
   task automatic send(bit fl, logic [23:0] pix);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = $urandom_range(0, 4);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= fl;
      req_tdata  <= {pix[7:0], pix[15:8], pix[23:16]};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_filtered(fl, pix);
      n_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_px.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, int unsigned v);
      csr_we <= 1'b1; csr_addr <= idx; csr_wdata <= CSR_DATA_W'(v);
      @(posedge clock);
      csr_we <= 1'b0;
      set_reg(idx, v);
      @(posedge clock);
   endtask

   // full frame of pixels with some flushes mixed in, then flush or pixel items until the frame completes
   task automatic send_frame(int unsigned mode);
      logic [23:0] p;
      for (int i = 0; i < img_w * img_h; i++) begin
         case (mode)
            0: p = 24'($urandom);
            1: p = (i % 2) ? 24'hFFFFFF : 24'h000000;
            default: p = {$urandom_range(0, 1) ? 8'hFF : 8'h00, 8'($urandom), 8'($urandom)};
         endcase
         if ($urandom_range(0, 15) == 0) send(1'b1, 24'($urandom)); // ignored mid-frame
         send(1'b0, p);
      end
      while (frame_in_done) send(1'($urandom_range(0, 1)), 24'($urandom));
   endtask

   typedef struct {
      bit          fl;
      logic [23:0] pix;
      bit          chk;
      logic [23:0] exp_rgb;
      bit          exp_last;
   } step_row_type;

   initial begin
      step_row_type steps [$];
      for (int i = 0; i < MAX_WIDTH; i++) begin
         upper_line[i] = '0; lower_line[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      img_w = WIDTH_RESET; img_h = HEIGHT_RESET; ksel = 0;
      restart();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: 1x1 identity frames read off at a glance
      write_reg(CSR_WIDTH, 1);
      write_reg(CSR_HEIGHT, 1);
      write_reg(CSR_KERNEL, 0);
      steps = '{
         '{1, 24'h123456, 0, 0, 0},         // flush mid-frame, ignored
         '{0, 24'hFFFFFF, 0, 0, 0},
         '{1, 24'h000000, 1, 24'hFFFFFF, 1},
         '{0, 24'h000000, 0, 0, 0},
         '{0, 24'hABCDEF, 1, 24'h000000, 1}, // pixel acting as flush
         '{0, 24'h80FF01, 0, 0, 0},
         '{1, 24'h000000, 1, 24'h80FF01, 1}
      };
      foreach (steps[i]) begin
         send(steps[i].fl, steps[i].pix);
         if (steps[i].chk &&
             (pending_px.size() == 0 ||
              pending_px[$] !== {steps[i].exp_last, steps[i].exp_rgb[7:0],
                                 steps[i].exp_rgb[15:8], steps[i].exp_rgb[23:16]})) begin
            $display("%0t: directed row %0d model exp %h", $time, i, steps[i].exp_rgb);
            errors++;
         end
      end
      drain();

      // directed: every kernel on small frames with extreme contents
      for (int k = 0; k < 16; k++) begin
         write_reg(CSR_KERNEL, k);
         write_reg(CSR_WIDTH, 3);
         write_reg(CSR_HEIGHT, 2);
         send_frame(1);
         drain();
      end

      // random: small geometries including the zero writes, all kernels
      while (n_sent < 450) begin
         int unsigned w, h;
         case ($urandom_range(0, 9))
            0: begin w = 1; h = 1; end
            1: begin w = 1; h = $urandom_range(1, 6); end
            2: begin w = 0; h = 0; end
            3: begin w = $urandom_range(1, 7); h = 1; end
            default: begin w = $urandom_range(1, 7); h = $urandom_range(1, 6); end
         endcase
         write_reg(CSR_WIDTH, w);
         write_reg(CSR_HEIGHT, h);
         write_reg(CSR_KERNEL, $urandom_range(0, 15));
         send_frame($urandom_range(0, 2));
         if ($urandom_range(0, 3) == 0) drain(); // sender waits for every result
         else begin
            drain();
         end
      end

      // abandoned frame: geometry write drops pending results
      write_reg(CSR_WIDTH, 4);
      write_reg(CSR_HEIGHT, 3);
      for (int i = 0; i < 6; i++) send(1'b0, 24'($urandom));
      drain();
      write_reg(CSR_HEIGHT, 2);
      send_frame(0);
      drain();

      $display("Covered %0d frames, %0d filtered pixels, all 16 kernel codes.",
               n_frames, n_rsp);
      if (errors == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
hdl/rcr_pkg.sv
hdl/rcr_mac.sv
hdl/rgb_conv3x3_reflect_unit.sv
tb/sv/tb.sv
